// ===== design/ala_pkg.sv =====
`default_nettype none

package ala_pkg;

  // Datapath width of the accumulator
  localparam int unsigned AccW = 12;
  // Widest shift amount; larger operands saturate here
  localparam int unsigned ShMax = 12;
  localparam int unsigned ShW = 4;

  // Operation codes
  typedef enum logic [3:0] {
    OP_LDAC   = 4'd0,
    OP_LDLINK = 4'd1,
    OP_ADD    = 4'd2,
    OP_AND    = 4'd3,
    OP_OR     = 4'd4,
    OP_CMA    = 4'd5,
    OP_CML    = 4'd6,
    OP_INC    = 4'd7,
    OP_NEG    = 4'd8,
    OP_CLA    = 4'd9,
    OP_CLL    = 4'd10,
    OP_CLR    = 4'd11,
    OP_RAR    = 4'd12,
    OP_RAL    = 4'd13,
    OP_SHR    = 4'd14,
    OP_SHL    = 4'd15
  } op_kind_t;

  // Result of one operation, flags included
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            link;
    logic            zero;
    logic            neg;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== design/ala_in_if.sv =====
`default_nettype none

// Operation word channel
interface ala_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [11:0] operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

`default_nettype wire

// ===== design/ala_out_if.sv =====
`default_nettype none

// Result word channel
interface ala_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] acc_out;
  logic        link_out;
  logic        is_zero;
  logic        is_negative;

  modport source (output valid, output acc_out, output link_out, output is_zero,
                  output is_negative, input ready);
  modport sink   (input valid, input acc_out, input link_out, input is_zero,
                  input is_negative, output ready);
endinterface

`default_nettype wire

// ===== design/ala_core.sv =====
`default_nettype none

// Single-pass ALU: one operation on the current accumulator and link
module ala_core (
  input  wire logic [3:0]                kind,
  input  wire logic [ala_pkg::AccW-1:0]  operand,
  input  wire logic [ala_pkg::AccW-1:0]  acc,
  input  wire logic                      link,
  output ala_pkg::alu_res_t              res
);

  logic [ala_pkg::ShW-1:0]  sh_n;
  logic [ala_pkg::AccW:0]   add_src;
  logic [ala_pkg::AccW:0]   sum;
  logic [ala_pkg::AccW:0]   shr_v;
  logic [ala_pkg::AccW:0]   shl_v;
  logic [ala_pkg::AccW-1:0] acc_nxt;
  logic                     link_nxt;
  ala_pkg::op_kind_t        op;

  assign op = ala_pkg::op_kind_t'(kind);

  // Shift amount saturates at the word width
  assign sh_n = (operand > ala_pkg::AccW'(ala_pkg::ShMax)) ? ala_pkg::ShW'(ala_pkg::ShMax)
                                                         : operand[ala_pkg::ShW-1:0];

  // Shared adder: add, increment, negate (complement then increment)
  always_comb begin
    case (op)
      ala_pkg::OP_ADD: add_src = {1'b0, acc} + {1'b0, operand};
      ala_pkg::OP_NEG: add_src = {1'b0, ~acc} + {{ala_pkg::AccW{1'b0}}, 1'b1};
      default:         add_src = {1'b0, acc} + {{ala_pkg::AccW{1'b0}}, 1'b1};
    endcase
  end
  assign sum = add_src;

  // Shifts: link sits above the accumulator for the right shift;
  // bit above the word catches the last bit out for the left shift
  assign shr_v = {link, acc} >> sh_n;
  assign shl_v = {1'b0, acc} << sh_n;

  always_comb begin
    acc_nxt  = acc;
    link_nxt = link;
    unique case (op)
      ala_pkg::OP_LDAC:   acc_nxt = operand;
      ala_pkg::OP_LDLINK: link_nxt = operand[0];
      ala_pkg::OP_ADD, ala_pkg::OP_INC, ala_pkg::OP_NEG: begin
        acc_nxt  = sum[ala_pkg::AccW-1:0];
        link_nxt = sum[ala_pkg::AccW];
      end
      ala_pkg::OP_AND:    acc_nxt = acc & operand;
      ala_pkg::OP_OR:     acc_nxt = acc | operand;
      ala_pkg::OP_CMA:    acc_nxt = ~acc;
      ala_pkg::OP_CML:    link_nxt = ~link;
      ala_pkg::OP_CLA:    acc_nxt = '0;
      ala_pkg::OP_CLL:    link_nxt = 1'b0;
      ala_pkg::OP_CLR: begin
        acc_nxt  = '0;
        link_nxt = 1'b0;
      end
      ala_pkg::OP_RAR: begin
        acc_nxt  = {link, acc[ala_pkg::AccW-1:1]};
        link_nxt = acc[0];
      end
      ala_pkg::OP_RAL: begin
        acc_nxt  = {acc[ala_pkg::AccW-2:0], link};
        link_nxt = acc[ala_pkg::AccW-1];
      end
      ala_pkg::OP_SHR: begin
        acc_nxt  = shr_v[ala_pkg::AccW-1:0];
        link_nxt = 1'b0;
      end
      ala_pkg::OP_SHL: begin
        acc_nxt  = shl_v[ala_pkg::AccW-1:0];
        link_nxt = shl_v[ala_pkg::AccW];
      end
    endcase
  end

  // Result with flags
  assign res.acc  = acc_nxt;
  assign res.link = link_nxt;
  assign res.zero = (acc_nxt == '0);
  assign res.neg  = acc_nxt[ala_pkg::AccW-1];

endmodule

`default_nettype wire

// ===== design/accumulator_link_alu.sv =====
`default_nettype none

// Channel   Dir  Payload                                     Handshake
// in_ch     in   kind[3:0], operand[11:0]                    valid/ready
// out_ch    out  acc_out[11:0], link_out, is_zero, is_negative valid/ready
//
// One word a cycle sustained while out_ch.ready stays high; an
// accepted word passes the input register, then the ALU into the
// result register and the accumulator/link.
// The accumulator/link feedback closes through the ALU.
// rst_n (synchronous) clears both stages and zeroes accumulator and link.
// A stalled result holds; the input stage still takes one word behind it.
module accumulator_link_alu (
  input  wire logic clk,
  input  wire logic rst_n,
  ala_in_if.sink    in_ch,
  ala_out_if.source out_ch
);

  logic                     in_vld_r, in_vld_nxt;
  logic [3:0]               kind_r;
  logic [ala_pkg::AccW-1:0] operand_r;
  logic                     out_vld_r, out_vld_nxt;
  ala_pkg::alu_res_t        res_r;
  ala_pkg::alu_res_t        res;
  logic [ala_pkg::AccW-1:0] acc_r;
  logic                     link_r;
  logic                     in_acc;
  logic                     adv;

  // Handshake
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  ala_core u_core (
    .kind    (kind_r),
    .operand (operand_r),
    .acc     (acc_r),
    .link    (link_r),
    .res     (res)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= '0;
      link_r    <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        acc_r  <= res.acc;
        link_r <= res.link;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= in_ch.kind;
      operand_r <= in_ch.operand;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.acc_out     = res_r.acc;
  assign out_ch.link_out    = res_r.link;
  assign out_ch.is_zero     = res_r.zero;
  assign out_ch.is_negative = res_r.neg;

endmodule

`default_nettype wire
